>>> rtl/saturating_unsigned_alu_macros.svh
// ----------------------------------------------------------------------------
// saturating unsigned alu assertion macros
// concurrent checks clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef SATURATING_UNSIGNED_ALU_MACROS_SVH
`define SATURATING_UNSIGNED_ALU_MACROS_SVH

// consequent must hold in the same cycle
`define SUA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sua assertion failed");

// consequent must hold in the next cycle
`define SUA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sua assertion failed");

`endif

>>> rtl/sua_pkg.sv
// ----------------------------------------------------------------------------
// sua_pkg
// shared types and constants of the saturating unsigned alu
// ----------------------------------------------------------------------------
`default_nettype none

package sua_pkg;

	localparam int FUNC_W = 4;
	localparam int OPND_W = 32;
	localparam int RES_W  = 32;

	typedef enum logic [FUNC_W-1:0] {
		FN_AND  = 4'd0,
		FN_OR   = 4'd1,
		FN_XOR  = 4'd2,
		FN_NOT  = 4'd3,
		FN_LOAD = 4'd4,
		FN_ADD  = 4'd5,
		FN_SUB  = 4'd6,
		FN_MUL  = 4'd7,
		FN_DIV  = 4'd8,
		FN_INC  = 4'd9,
		FN_DEC  = 4'd10
	} sua_func_t;

	typedef struct packed {
		logic start;
		logic step;
	} sua_ctl_t;

endpackage

`default_nettype wire

>>> rtl/sua_serial_unit.sv
// ----------------------------------------------------------------------------
// sua_serial_unit
// bit-serial logic, add and subtract unit, lsb first, one bit per step
// ----------------------------------------------------------------------------
`default_nettype none

module sua_serial_unit #(
	parameter int DW = 32
) (
	input  logic                      clk,
	input  sua_pkg::sua_ctl_t         ctl,
	input  logic [sua_pkg::FUNC_W-1:0] fn,
	input  logic [DW-1:0]             a,
	input  logic [DW-1:0]             b,
	output logic [DW-1:0]             res
);
	import sua_pkg::*;

	sua_func_t     fn_q;
	logic [DW-1:0] a_q;
	logic [DW-1:0] b_q;
	logic [DW-1:0] r_q;
	logic          c_q;
	logic          r_bit;
	logic          c_next;
	sua_func_t     fn_in;

	assign fn_in = sua_func_t'(fn);

	always_comb begin
		r_bit  = a_q[0];
		c_next = c_q;
		case (fn_q) inside
			FN_AND:  r_bit = a_q[0] & b_q[0];
			FN_OR:   r_bit = a_q[0] | b_q[0];
			FN_XOR:  r_bit = a_q[0] ^ b_q[0];
			FN_NOT:  r_bit = ~a_q[0];
			FN_LOAD: r_bit = b_q[0];
			FN_ADD, FN_INC: begin
				r_bit  = a_q[0] ^ b_q[0] ^ c_q;
				c_next = (a_q[0] & b_q[0]) | ((a_q[0] ^ b_q[0]) & c_q);
			end
			FN_SUB, FN_DEC: begin
				r_bit  = a_q[0] ^ b_q[0] ^ c_q;
				c_next = (~a_q[0] & b_q[0]) | (~(a_q[0] ^ b_q[0]) & c_q);
			end
			default: r_bit = a_q[0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			fn_q <= fn_in;
			a_q  <= a;
			b_q  <= (fn_in == FN_INC || fn_in == FN_DEC) ? DW'(1) : b;
			c_q  <= 1'b0;
		end else if (ctl.step) begin
			a_q <= {1'b0, a_q[DW-1:1]};
			b_q <= {1'b0, b_q[DW-1:1]};
			r_q <= {r_bit, r_q[DW-1:1]};
			c_q <= c_next;
		end
	end

	// carry saturates high, borrow clamps at zero
	always_comb begin
		case (fn_q) inside
			FN_ADD, FN_INC: res = c_q ? '1 : r_q;
			FN_SUB, FN_DEC: res = c_q ? '0 : r_q;
			default:        res = r_q;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/sua_muldiv_unit.sv
// ----------------------------------------------------------------------------
// sua_muldiv_unit
// shift-add multiplier and restoring shift-subtract divider, one bit per step
// ----------------------------------------------------------------------------
`default_nettype none

module sua_muldiv_unit #(
	parameter int DW = 32
) (
	input  logic                      clk,
	input  sua_pkg::sua_ctl_t         ctl,
	input  logic [sua_pkg::FUNC_W-1:0] fn,
	input  logic [DW-1:0]             a,
	input  logic [DW-1:0]             b,
	output logic [DW-1:0]             res
);
	import sua_pkg::*;

	logic [DW-1:0] hi_q;
	logic [DW-1:0] lo_q;
	logic [DW-1:0] m_q;
	logic          div_q;
	logic          nz_q;
	logic [DW:0]   sum;
	logic [DW:0]   trial;
	logic          is_div;

	assign is_div = (sua_func_t'(fn) == FN_DIV);
	assign sum    = {1'b0, hi_q} + (lo_q[0] ? {1'b0, m_q} : '0);
	assign trial  = {hi_q, lo_q[DW-1]} - {1'b0, m_q};

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			div_q <= is_div;
			nz_q  <= (a != '0);
			hi_q  <= '0;
			lo_q  <= is_div ? a : b;
			m_q   <= is_div ? b : a;
		end else if (ctl.step) begin
			if (div_q) begin
				if (!trial[DW]) begin
					hi_q <= trial[DW-1:0];
					lo_q <= {lo_q[DW-2:0], 1'b1};
				end else begin
					hi_q <= {hi_q[DW-2:0], lo_q[DW-1]};
					lo_q <= {lo_q[DW-2:0], 1'b0};
				end
			end else begin
				hi_q <= sum[DW:1];
				lo_q <= {sum[0], lo_q[DW-1:1]};
			end
		end
	end

	// divide by zero gives all ones for a nonzero dividend, else zero; a nonzero upper product half means overflow
	always_comb begin
		if (div_q) begin
			if (m_q == '0) begin
				res = nz_q ? '1 : '0;
			end else begin
				res = lo_q;
			end
		end else begin
			res = (hi_q != '0) ? '1 : lo_q;
		end
	end

endmodule

`default_nettype wire

>>> rtl/saturating_unsigned_alu.sv
// ----------------------------------------------------------------------------
// saturating_unsigned_alu: bit-serial accumulator alu with saturation
// one bit per cycle in the run state, then the result is registered in the finish state
// a new request is taken only while idle, so one transaction ends before the next is accepted
// arst_n clears the accumulator, the sequencer and the result valid
// ----------------------------------------------------------------------------
`default_nettype none
`include "saturating_unsigned_alu_macros.svh"

module saturating_unsigned_alu #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic [sua_pkg::FUNC_W-1:0] func,
	input  logic [sua_pkg::OPND_W-1:0] operand,
	input  logic                       to_self,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic [sua_pkg::RES_W-1:0]  result
);
	import sua_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int CW = $clog2(DW);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  cnt_q;
	sua_func_t      fn_q;
	logic           to_self_q;
	logic [DW-1:0]  acc_q;
	logic           rsp_valid_q;
	logic [RES_W-1:0] res_q;

	sua_ctl_t       ctl;
	logic           accept;
	logic           fin_done;
	logic [DW-1:0]  opnd_dw;
	logic [DW-1:0]  ser_res;
	logic [DW-1:0]  md_res;
	logic [DW-1:0]  fin_res;
	logic [RES_W-1:0] res_ext;

	generate
		if (DW > OPND_W) begin : g_opnd_wide
			assign opnd_dw = {{(DW-OPND_W){1'b0}}, operand};
		end else begin : g_opnd_narrow
			assign opnd_dw = operand[DW-1:0];
		end
		if (DW >= RES_W) begin : g_res_wide
			assign res_ext = fin_res[RES_W-1:0];
		end else begin : g_res_narrow
			assign res_ext = {{(RES_W-DW){1'b0}}, fin_res};
		end
	endgenerate

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign ctl.start = accept;
	assign ctl.step  = (state_q == ST_RUN);
	assign fin_done  = (state_q == ST_FIN) && (!rsp_valid_q || !rsp_stall);
	assign fin_res   = (fn_q == FN_MUL || fn_q == FN_DIV) ? md_res : ser_res;
	assign rsp_valid = rsp_valid_q;
	assign result    = res_q;

	sua_serial_unit #(
		.DW(DW)
	) u_serial (
		.clk(clk),
		.ctl(ctl),
		.fn (func),
		.a  (acc_q),
		.b  (opnd_dw),
		.res(ser_res)
	);

	sua_muldiv_unit #(
		.DW(DW)
	) u_muldiv (
		.clk(clk),
		.ctl(ctl),
		.fn (func),
		.a  (acc_q),
		.b  (opnd_dw),
		.res(md_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			fn_q        <= FN_AND;
			to_self_q   <= 1'b0;
			acc_q       <= '0;
			rsp_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall && !fin_done) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fn_q      <= sua_func_t'(func);
						to_self_q <= to_self;
						cnt_q     <= CW'(DW-1);
						state_q   <= ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_done) begin
						res_q       <= res_ext;
						rsp_valid_q <= 1'b1;
						// unused codes never write back
						if (to_self_q && fn_q <= FN_DEC) begin
							acc_q <= fin_res;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`SUA_ASSERT_NEXT(a_accept_runs, accept, state_q == ST_RUN)
	`SUA_ASSERT_NEXT(a_run_ends, state_q == ST_RUN && cnt_q == '0, state_q == ST_FIN)
	`SUA_ASSERT_NEXT(a_acc_only_fin, state_q != ST_FIN, $stable(acc_q))
	`SUA_ASSERT_NEXT(a_rsp_only_fin, state_q != ST_FIN && !rsp_valid_q, !rsp_valid_q)
	`SUA_ASSERT_NOW(a_fin_loads, fin_done, state_q == ST_FIN)

endmodule

`default_nettype wire
